>>> rtl/dlts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_pkg - shared types and constants of the delta-list task scheduler
// Holds the list depth, the item kind and add status codes, and the command
// and read structs that pass between the sequencer and the entry store.
// ----------------------------------------------------------------------------
package dlts_pkg;

    // list depth and slot index width
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);

    typedef logic [IDX_W-1:0] t_idx;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    // add status codes of a result beat
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2,
        ST_FULL   = 2'd3
    } t_add_status;

    // operations on the entry store
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_INSERT     = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_SET_DELTA0 = 3'd3,
        OP_INC_PEND0  = 3'd4
    } t_store_op;

    // sequencer to store: one operation per cycle, idx also selects the read slot
    typedef struct packed {
        t_store_op   op;
        t_idx        idx;
        logic [7:0]  task_id;
        logic [15:0] delta;
        logic [15:0] period;
        logic [15:0] adj_delta;
    } t_store_cmd;

    // store to sequencer: selected slot, head slot and last slot
    typedef struct packed {
        logic        sel_valid;
        logic [15:0] sel_delta;
        logic        head_valid;
        logic [7:0]  head_task;
        logic [15:0] head_period;
        logic [7:0]  head_pending;
        logic        last_valid;
    } t_store_rd;

endpackage

>>> rtl/dlts_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_alu - shared subtract and compare unit
// One 16-bit subtractor serves the list walk, the neighbour delay repair and
// the head countdown; it also reports whether a is strictly greater than b.
// ----------------------------------------------------------------------------
module dlts_alu
    import dlts_pkg::*;
(
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_diff,
    output logic        o_gt
);

    logic [16:0] diff_ext;

    // difference with borrow out
    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[15:0];
    assign o_gt     = !diff_ext[16] && (diff_ext[15:0] != 16'd0);

endmodule

>>> rtl/dlts_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_store - entry register file of the delta list
// Holds valid, task, delta, period and pending per slot; inserts with a shift
// of the tail, removes the head with a shift towards it, and updates the head.
// ----------------------------------------------------------------------------
module dlts_store
    import dlts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_cmd i_cmd,
    output t_store_rd  o_rd
);

    logic [MAX_TASKS-1:0] r_valid;
    logic [7:0]           r_task    [MAX_TASKS];
    logic [15:0]          r_delta   [MAX_TASKS];
    logic [15:0]          r_period  [MAX_TASKS];
    logic [7:0]           r_pending [MAX_TASKS];

    // neighbour taps: up is the slot before, dn the slot after
    logic [MAX_TASKS-1:0] up_valid;
    logic [7:0]           up_task    [MAX_TASKS];
    logic [15:0]          up_delta   [MAX_TASKS];
    logic [15:0]          up_period  [MAX_TASKS];
    logic [7:0]           up_pending [MAX_TASKS];
    logic [MAX_TASKS-1:0] dn_valid;
    logic [7:0]           dn_task    [MAX_TASKS];
    logic [15:0]          dn_delta   [MAX_TASKS];
    logic [15:0]          dn_period  [MAX_TASKS];
    logic [7:0]           dn_pending [MAX_TASKS];

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_nb
            if (g == 0) begin : g_first
                assign up_valid[g]   = 1'b0;
                assign up_task[g]    = 8'd0;
                assign up_delta[g]   = 16'd0;
                assign up_period[g]  = 16'd0;
                assign up_pending[g] = 8'd0;
            end else begin : g_mid_up
                assign up_valid[g]   = r_valid[g-1];
                assign up_task[g]    = r_task[g-1];
                assign up_delta[g]   = r_delta[g-1];
                assign up_period[g]  = r_period[g-1];
                assign up_pending[g] = r_pending[g-1];
            end
            if (g == MAX_TASKS - 1) begin : g_last
                assign dn_valid[g]   = 1'b0;
                assign dn_task[g]    = 8'd0;
                assign dn_delta[g]   = 16'd0;
                assign dn_period[g]  = 16'd0;
                assign dn_pending[g] = 8'd0;
            end else begin : g_mid_dn
                assign dn_valid[g]   = r_valid[g+1];
                assign dn_task[g]    = r_task[g+1];
                assign dn_delta[g]   = r_delta[g+1];
                assign dn_period[g]  = r_period[g+1];
                assign dn_pending[g] = r_pending[g+1];
            end
        end
    endgenerate

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_INSERT: begin
                    for (int k = 0; k < MAX_TASKS; k++) begin
                        if (t_idx'(k) == i_cmd.idx) begin
                            r_valid[k] <= 1'b1;
                        end else if (t_idx'(k) > i_cmd.idx) begin
                            r_valid[k] <= up_valid[k];
                        end
                    end
                end
                OP_REMOVE: begin
                    r_valid <= dn_valid;
                end
                default: begin
                end
            endcase
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_INSERT: begin
                for (int k = 0; k < MAX_TASKS; k++) begin
                    if (t_idx'(k) == i_cmd.idx) begin
                        r_task[k]    <= i_cmd.task_id;
                        r_delta[k]   <= i_cmd.delta;
                        r_period[k]  <= i_cmd.period;
                        r_pending[k] <= 8'd0;
                    end else if (t_idx'(k) > i_cmd.idx) begin
                        r_task[k]    <= up_task[k];
                        r_delta[k]   <= (t_idx'(k - 1) == i_cmd.idx) ? i_cmd.adj_delta
                                                                     : up_delta[k];
                        r_period[k]  <= up_period[k];
                        r_pending[k] <= up_pending[k];
                    end
                end
            end
            OP_REMOVE: begin
                for (int k = 0; k < MAX_TASKS; k++) begin
                    r_task[k]    <= dn_task[k];
                    r_delta[k]   <= dn_delta[k];
                    r_period[k]  <= dn_period[k];
                    r_pending[k] <= dn_pending[k];
                end
            end
            OP_SET_DELTA0: begin
                r_delta[0] <= i_cmd.delta;
            end
            OP_INC_PEND0: begin
                if (r_pending[0] != 8'hFF) begin
                    r_pending[0] <= r_pending[0] + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // read side
    assign o_rd.sel_valid    = r_valid[i_cmd.idx];
    assign o_rd.sel_delta    = r_delta[i_cmd.idx];
    assign o_rd.head_valid   = r_valid[0];
    assign o_rd.head_task    = r_task[0];
    assign o_rd.head_period  = r_period[0];
    assign o_rd.head_pending = r_pending[0];
    assign o_rd.last_valid   = r_valid[MAX_TASKS-1];

endmodule

>>> rtl/delta_list_task_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_core - sorted timer queue with relative delays
// Sequencer over a shared subtractor and a shifting entry store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat: tuser holds the kind (add, tick,
//   dispatch), tdata the task id, delay and period. Every command gives
//   exactly one result beat on m_axis: run valid, run task, add status and
//   add position.
//   States from the accepting edge to the result register being loaded:
//     tick: tick, output; unused kind, rejected or full add: output only;
//     add: walk past W entries (W in 0..MAX_TASKS-1), insert, output;
//     dispatch: dispatch, then walk and insert if it re-adds, output.
//   The walk steps one list entry per cycle through the shared subtractor;
//   the block takes one command at a time and s_axis_tready is low while a
//   command is at work. The next command can be accepted in the cycle after
//   the result register has been loaded.
//   A finished result sits in an output register; the next command is
//   accepted while it waits. If the receiver stalls, the following result
//   waits in the sequencer until the register drains.
//   Reset (synchronous, active low) empties the list at once and drops any
//   pending result beat.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_core
    import dlts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] task_id, [23:8] delay_ticks, [39:24] period_ticks
    input  logic [39:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] run_valid, [8:1] run_task, [10:9] add_status, [16:11] add_position,
    // [23:17] zero
    output logic [23:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_INSERT = 6'b000100,
        S_TICK   = 6'b001000,
        S_DISP   = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_idx        r_idx, n_idx;
    logic [7:0]  r_task, n_task;
    logic [15:0] r_delay, n_delay;
    logic [15:0] r_period, n_period;
    logic        r_readd, n_readd;
    logic        r_run_valid, n_run_valid;
    logic [7:0]  r_run_task, n_run_task;
    t_add_status r_status, n_status;
    logic [5:0]  r_pos, n_pos;
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_data, n_out_data;

    t_store_cmd  cmd;
    t_store_rd   rd;
    logic [15:0] alu_a, alu_b, alu_diff;
    logic        alu_gt;
    logic        in_beat;
    t_kind       in_kind;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = t_kind'(s_axis_tuser);

    dlts_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_gt   (alu_gt)
    );

    dlts_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rd    (rd)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_task      = r_task;
        n_delay     = r_delay;
        n_period    = r_period;
        n_readd     = r_readd;
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_status    = r_status;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        cmd.op        = OP_NOP;
        cmd.idx       = r_idx;
        cmd.task_id   = r_task;
        cmd.delta     = alu_diff;
        cmd.period    = r_period;
        cmd.adj_delta = alu_diff;

        alu_a = r_delay;
        alu_b = rd.sel_delta;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_task      = s_axis_tdata[7:0];
                    n_delay     = s_axis_tdata[23:8];
                    n_period    = s_axis_tdata[39:24];
                    n_idx       = '0;
                    n_readd     = 1'b0;
                    n_run_valid = 1'b0;
                    n_run_task  = 8'd0;
                    n_status    = ST_NONE;
                    n_pos       = 6'd0;
                    unique case (in_kind)
                        KIND_ADD: begin
                            if (s_axis_tdata[23:8] == 16'd0 &&
                                s_axis_tdata[39:24] == 16'd0) begin
                                n_status = ST_REJECT;
                                n_state  = S_OUT;
                            end else if (rd.last_valid) begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        KIND_TICK:     n_state = S_TICK;
                        KIND_DISPATCH: n_state = S_DISP;
                        default:       n_state = S_OUT;
                    endcase
                end
            end
            // one entry per cycle: step past it while the delay is larger
            S_WALK: begin
                alu_a = r_delay;
                alu_b = rd.sel_delta;
                if (rd.sel_valid && alu_gt) begin
                    n_delay = alu_diff;
                    n_idx   = r_idx + t_idx'(1);
                end else begin
                    n_state = S_INSERT;
                end
            end
            // shift tail, place entry, repair the follower's delay
            S_INSERT: begin
                alu_a     = rd.sel_delta;
                alu_b     = r_delay;
                cmd.op    = OP_INSERT;
                cmd.delta = r_delay;
                if (!r_readd) begin
                    n_status = ST_ACCEPT;
                    n_pos    = 6'(r_idx);
                end
                n_state = S_OUT;
            end
            // head countdown or pending count
            S_TICK: begin
                alu_a = rd.sel_delta;
                alu_b = 16'd1;
                if (rd.head_valid) begin
                    if (rd.sel_delta == 16'd0) begin
                        cmd.op = OP_INC_PEND0;
                    end else begin
                        cmd.op = OP_SET_DELTA0;
                    end
                end
                n_state = S_OUT;
            end
            // release a pending head, re-add periodic tasks
            S_DISP: begin
                if (rd.head_valid && rd.head_pending != 8'd0) begin
                    n_run_valid = 1'b1;
                    n_run_task  = rd.head_task;
                    n_task      = rd.head_task;
                    n_delay     = rd.head_period;
                    n_period    = rd.head_period;
                    cmd.op      = OP_REMOVE;
                    if (rd.head_period != 16'd0) begin
                        n_readd = 1'b1;
                        n_idx   = '0;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_pos, r_status, r_run_task, r_run_valid};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_task      <= n_task;
        r_delay     <= n_delay;
        r_period    <= n_period;
        r_readd     <= n_readd;
        r_run_valid <= n_run_valid;
        r_run_task  <= n_run_task;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_out_data  <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the walk never meets a full list
    a_walk_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !rd.last_valid)
        else $error("walk started on a full list");

    // an entry goes in front of any later entry with a larger or equal delay
    a_insert_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT && rd.sel_valid) |-> (r_delay <= rd.sel_delta))
        else $error("insert would underflow the following delay");

    // a re-add after dispatch reports no add status
    a_readd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_run_valid) |-> (r_status == ST_NONE && r_pos == 6'd0))
        else $error("dispatch result carries an add status");

    // a result beat is only loaded from the output state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || m_axis_tready) && n_out_valid |-> (r_state == S_OUT))
        else $error("result beat loaded outside the output state");

endmodule

>>> dv/tb_delta_list_task_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_list_task_scheduler_core - self-checking bench for the timer queue
// Drives add, tick, dispatch and unused-kind commands with bursty gaps,
// stalls the result stream on its own pattern, and compares every result beat
// against a delta-list model of the queue kept in a small scoreboard class.
// ----------------------------------------------------------------------------

import dlts_pkg::*;

// one result beat, fields in tdata order from the highest bit
typedef struct packed {
    logic [6:0]  pad;
    logic [5:0]  add_position;
    t_add_status add_status;
    logic [7:0]  run_task;
    logic        run_valid;
} sched_result_t;

// delta-list model and the queue of results it predicts
class sched_scoreboard;
    bit          slot_valid   [MAX_TASKS];
    logic [7:0]  slot_task    [MAX_TASKS];
    logic [15:0] slot_delta   [MAX_TASKS];
    logic [15:0] slot_period  [MAX_TASKS];
    logic [7:0]  slot_pending [MAX_TASKS];
    sched_result_t expected_q[$];
    int errors;
    int beat_no;

    function new();
        errors  = 0;
        beat_no = 0;
        clear_list();
    endfunction

    function void clear_slot(input int s);
        slot_valid[s]   = 1'b0;
        slot_task[s]    = '0;
        slot_delta[s]   = '0;
        slot_period[s]  = '0;
        slot_pending[s] = '0;
    endfunction

    function void clear_list();
        int s;
        for (s = 0; s < MAX_TASKS; s++) clear_slot(s);
    endfunction

    function void move_slot(input int dst, input int src);
        slot_valid[dst]   = slot_valid[src];
        slot_task[dst]    = slot_task[src];
        slot_delta[dst]   = slot_delta[src];
        slot_period[dst]  = slot_period[src];
        slot_pending[dst] = slot_pending[src];
    endfunction

    // walk past earlier deadlines, open a slot and shorten the follower
    function t_add_status insert_task(input logic [7:0] id, input logic [15:0] delay,
                                      input logic [15:0] period, output int pos);
        int i;
        int j;
        pos = 0;
        i   = 0;
        if (delay == 16'd0 && period == 16'd0) return ST_REJECT;
        if (slot_valid[MAX_TASKS-1]) return ST_FULL;
        while (i < MAX_TASKS && slot_valid[i] && delay > slot_delta[i]) begin
            delay = delay - slot_delta[i];
            i++;
        end
        if (i >= MAX_TASKS) return ST_FULL;
        for (j = MAX_TASKS - 1; j > i; j--) move_slot(j, j - 1);
        slot_valid[i]   = 1'b1;
        slot_task[i]    = id;
        slot_delta[i]   = delay;
        slot_period[i]  = period;
        slot_pending[i] = '0;
        if (i + 1 < MAX_TASKS && slot_valid[i+1])
            slot_delta[i+1] = slot_delta[i+1] - delay;
        pos = i;
        return ST_ACCEPT;
    endfunction

    function void remove_head();
        int s;
        for (s = 0; s + 1 < MAX_TASKS; s++) move_slot(s, s + 1);
        clear_slot(MAX_TASKS - 1);
    endfunction

    // accepted command: update the list and queue the expected beat
    function void note_item(input t_kind kind, input logic [7:0] id,
                            input logic [15:0] delay, input logic [15:0] period);
        sched_result_t exp;
        int            pos;
        logic [7:0]    head_task;
        logic [15:0]   head_period;
        exp.pad          = '0;
        exp.add_position = '0;
        exp.add_status   = ST_NONE;
        exp.run_task     = '0;
        exp.run_valid    = 1'b0;
        case (kind)
            KIND_ADD: begin
                exp.add_status   = insert_task(id, delay, period, pos);
                exp.add_position = 6'(pos);
            end
            KIND_TICK: begin
                if (slot_valid[0]) begin
                    if (slot_delta[0] == 16'd0) begin
                        if (slot_pending[0] != 8'hFF) slot_pending[0]++;
                    end else begin
                        slot_delta[0]--;
                    end
                end
            end
            KIND_DISPATCH: begin
                if (slot_valid[0] && slot_pending[0] != 8'd0) begin
                    head_task     = slot_task[0];
                    head_period   = slot_period[0];
                    exp.run_valid = 1'b1;
                    exp.run_task  = head_task;
                    remove_head();
                    if (head_period != 16'd0)
                        void'(insert_task(head_task, head_period, head_period, pos));
                end
            end
            default: ;
        endcase
        expected_q.push_back(exp);
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] beat %0d: %s mismatch, got 0x%0h want 0x%0h",
                 $time, beat_no, what, got, want);
        errors++;
    endtask

    // result beat against the oldest expectation, field by field
    task check_result(input logic [23:0] data);
        sched_result_t got;
        sched_result_t exp;
        beat_no++;
        got = data;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", data, '0);
        end else begin
            exp = expected_q.pop_front();
            if (got.run_valid !== exp.run_valid)
                report_mismatch("run_valid", got.run_valid, exp.run_valid);
            if (got.run_task !== exp.run_task)
                report_mismatch("run_task", got.run_task, exp.run_task);
            if (got.add_status !== exp.add_status)
                report_mismatch("add_status", got.add_status, exp.add_status);
            if (got.add_position !== exp.add_position)
                report_mismatch("add_position", got.add_position, exp.add_position);
            if (got.pad !== '0)
                report_mismatch("padding", got.pad, '0);
        end
    endtask

    task close_out();
        if (expected_q.size() != 0)
            report_mismatch("beats never seen", expected_q.size(), '0);
    endtask
endclass

module tb_delta_list_task_scheduler_core;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 60;

    // stimulus mixes for the random part
    localparam int MIX_BLEND = 0;
    localparam int MIX_FILL  = 1;
    localparam int MIX_DRAIN = 2;
    localparam int MIX_STORM = 3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = KIND_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    sched_scoreboard sb;
    int items_sent;
    int cycle_count;
    int rx_mode = 0;
    int rx_left = 0;

    delta_list_task_scheduler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall pattern: free-running, random, sparse and long stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(10, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_left % 24 == 0);
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // hold one command beat until it is taken; valid stays up for the next beat
    task automatic send_cmd(input t_kind kind, input logic [7:0] id,
                            input logic [15:0] delay, input logic [15:0] period);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {period, delay, id};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, id, delay, period);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // mostly short delays so heads fall due, some wide ones to reach every bit
    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 6));
        if (r < 80) return 16'($urandom_range(0, 64));
        if (r < 92) return 16'($urandom_range(0, 1000));
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 16'd0;
        if (r < 80) return 16'($urandom_range(1, 16));
        if (r < 90) return 16'($urandom_range(0, 300));
        return 16'($urandom());
    endfunction

    function automatic t_kind pick_kind(input int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (r < 70) ? KIND_ADD : (r < 85) ? KIND_TICK : KIND_DISPATCH;
            MIX_DRAIN: return (r < 50) ? KIND_TICK : KIND_DISPATCH;
            MIX_STORM: return KIND_TICK;
            default:   return (r < 30) ? KIND_ADD : (r < 75) ? KIND_TICK :
                              (r < 97) ? KIND_DISPATCH : KIND_NONE;
        endcase
    endfunction

    initial begin
        int     burst_left;
        int     seg_left;
        int     seg_no;
        int     mix;
        int     k;
        t_kind  kind;

        sb         = new();
        items_sent = 0;
        burst_left = 0;
        seg_left   = 0;
        seg_no     = 0;
        mix        = MIX_BLEND;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, unused kind, rejection, ordering, pending handling
        send_cmd(KIND_TICK,     8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_NONE,     8'hFF, 16'hFFFF, 16'hFFFF);
        send_cmd(KIND_ADD,      8'h01, 16'h0000, 16'h0000);
        send_cmd(KIND_ADD,      8'hFF, 16'hFFFF, 16'hFFFF);
        send_cmd(KIND_ADD,      8'h00, 16'd5,    16'd0);
        // same remaining delay goes in front
        send_cmd(KIND_ADD,      8'h11, 16'd5,    16'd3);
        send_cmd(KIND_ADD,      8'h22, 16'd0,    16'd7);
        // due head but nothing owed yet
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_TICK,     8'h00, 16'h0000, 16'h0000);
        // push a head with a pending count back one slot
        send_cmd(KIND_ADD,      8'h33, 16'd0,    16'd9);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_TICK,     8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_TICK,     8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        for (k = 0; k < 6; k++)
            send_cmd(KIND_TICK, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        send_cmd(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000);

        // random segments of one mix each, sent in bursts with gaps
        while (items_sent < ITEM_TARGET) begin
            if (seg_left == 0) begin
                seg_no++;
                if (seg_no == 3 || $urandom_range(0, 15) == 0) begin
                    // long tick run drives the head's owed count into saturation
                    mix      = MIX_STORM;
                    seg_left = $urandom_range(260, 300);
                end else begin
                    mix      = $urandom_range(MIX_BLEND, MIX_DRAIN);
                    seg_left = $urandom_range(20, 120);
                end
            end
            seg_left--;
            kind = pick_kind(mix);
            if (kind == KIND_ADD)
                send_cmd(kind, 8'($urandom()), pick_delay(), pick_period());
            else
                send_cmd(kind, 8'($urandom()), 16'($urandom()), 16'($urandom()));
            if (burst_left == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst_left = $urandom_range(40, 160);
                end else begin
                    idle_cycles($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end else begin
                burst_left--;
            end
        end

        // drain and settle
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/dlts_pkg.sv
rtl/dlts_alu.sv
rtl/dlts_store.sv
rtl/delta_list_task_scheduler_core.sv
dv/tb_delta_list_task_scheduler_core.sv
